// ===== rtl/core/casefold_wildcard_substring_match_assert.svh =====
// Assertion macros shared by the matcher RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CASEFOLD_WILDCARD_SUBSTRING_MATCH_ASSERT_SVH
`define CASEFOLD_WILDCARD_SUBSTRING_MATCH_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define CWSM_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked only outside reset.
`define CWSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/cwsm_pkg.sv =====
// Package for the case-folding wildcard substring matcher.
// Holds widths, character codes, register indexes, stream state types and helpers.
// Depends on nothing.
package cwsm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = 5;
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef struct packed {
        logic [POS_W-1:0] active;
        logic [POS_W-1:0] pend0;
        logic [POS_W-1:0] pend1;
        logic [POS_W-1:0] pend2;
        logic [1:0]       cont_left;
        logic             sticky;
    } stream_state_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bytes;
    } pattern_cfg_t;

    localparam stream_state_t STREAM_RESET = '{
        active:    POS_W'(1),
        pend0:     '0,
        pend1:     '0,
        pend2:     '0,
        cont_left: 2'd0,
        sticky:    1'b0
    };

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | CASE_BIT) : b;
    endfunction

    // Bytes that follow a lead byte in the same UTF-8 character.
    function automatic logic [1:0] char_extra(input logic [7:0] b);
        logic [1:0] e;
        e = 2'd0;
        if (b >= 8'hC0 && b <= 8'hDF) e = 2'd1;
        else if (b >= 8'hE0 && b <= 8'hEF) e = 2'd2;
        else if (b >= 8'hF0 && b <= 8'hF7) e = 2'd3;
        return e;
    endfunction

    // Every live star position also makes the following position live.
    // Runs of stars are resolved with a log-depth prefix network.
    function automatic logic [POS_W-1:0] star_close(input logic [POS_W-1:0] set,
                                                    input logic [MAX_PATTERN-1:0] star);
        logic [POS_W-1:0] g;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] gn;
        logic [POS_W-1:0] pn;
        g = set;
        p = {star, 1'b0};
        for (int k = 1; k < POS_W; k = k * 2)
        begin
            gn = g;
            pn = p;
            for (int i = k; i < POS_W; i++)
            begin
                gn[i] = g[i] | (p[i] & g[i-k]);
                pn[i] = p[i] & p[i-k];
            end
            g = gn;
            p = pn;
        end
        return g;
    endfunction

endpackage

// ===== rtl/core/cwsm_step.sv =====
// Next-state logic of the matcher for one text transaction.
// Uses cwsm_pkg for the state type, character codes and the star closure.
module cwsm_step (
    input  cwsm_pkg::stream_state_t state_cur,
    input  cwsm_pkg::pattern_cfg_t  pattern,
    input  logic [7:0]              text_byte,
    input  logic                    byte_valid,
    input  logic                    last_byte,
    output cwsm_pkg::stream_state_t state_next,
    output logic                    found
);
    import cwsm_pkg::*;

    logic [LEN_W-1:0]       n;
    logic [MAX_PATTERN-1:0] is_star;
    logic [MAX_PATTERN-1:0] is_quest;
    logic [MAX_PATTERN-1:0] is_hit;
    logic [7:0]             pb;
    logic [7:0]             folded;
    logic [1:0]             extra;
    logic [POS_W-1:0]       s0;
    logic [POS_W-1:0]       s1;
    logic [POS_W-1:0]       s2;
    logic [POS_W-1:0]       s3;
    logic [POS_W-1:0]       jump;
    logic [POS_W-1:0]       nxt;
    stream_state_t          after;
    stream_state_t          taken;

    assign n      = (pattern.len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern.len;
    assign folded = fold_byte(text_byte);
    assign extra  = char_extra(text_byte);

    always_comb
    begin
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            pb          = pattern.bytes[8*p +: 8];
            is_star[p]  = (LEN_W'(p) < n) && (pb == CH_STAR);
            is_quest[p] = (LEN_W'(p) < n) && (pb == CH_QUEST);
            is_hit[p]   = (LEN_W'(p) < n) && (pb != CH_STAR) && (pb != CH_QUEST)
                          && (fold_byte(pb) == folded);
        end
    end

    always_comb
    begin
        // A new match may start only on a character boundary.
        s0 = state_cur.active | ((state_cur.cont_left == 2'd0) ? POS_W'(1) : '0);
        s1 = star_close(s0, is_star);

        // Stars stay on their position, question marks advance one position;
        // both complete only when the current character ends.
        jump = ({1'b0, s1[MAX_PATTERN-1:0] & is_star})
             | ({s1[MAX_PATTERN-1:0] & is_quest, 1'b0});

        nxt = {s1[MAX_PATTERN-1:0] & is_hit, 1'b0} | state_cur.pend0
            | ((extra == 2'd0) ? jump : '0);
        s2  = star_close(nxt, is_star);

        after.active    = s2;
        after.pend0     = state_cur.pend1 | ((extra == 2'd1) ? jump : '0);
        after.pend1     = state_cur.pend2 | ((extra == 2'd2) ? jump : '0);
        after.pend2     = (extra == 2'd3) ? jump : '0;
        after.cont_left = (state_cur.cont_left == 2'd0) ? extra : state_cur.cont_left - 2'd1;
        after.sticky    = state_cur.sticky | s1[n] | s2[n];

        taken = byte_valid ? after : state_cur;

        // At the text end any unfinished character step counts as complete.
        s3    = star_close(taken.active | taken.pend0 | taken.pend1 | taken.pend2, is_star);
        found = taken.sticky | s3[n];

        state_next = last_byte ? STREAM_RESET : taken;
    end

endmodule

// ===== rtl/core/casefold_wildcard_substring_match.sv =====
// Top level of the case-folding wildcard substring matcher.
// Depends on cwsm_pkg, cwsm_step and the assertion macro header.
//
// Usage:
// The text channel (text_valid, text_stall) carries one transaction per text
// byte with text_byte, byte_valid and last_byte. A transaction with byte_valid
// low consumes no byte; with last_byte high it still ends the text, so a lone
// such transaction searches an empty text.
// The result channel (result_valid, result_stall) carries one transaction,
// found, for each text transaction that has last_byte high, and none otherwise.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// pattern_length (index 0), pattern bytes 0..7 (index 1) and 8..15 (index 2);
// cfg_ready is always high. Writes must be made while no text is in flight;
// the block itself does not enforce this. A text byte is registered in the input
// register on acceptance; processing a last byte there loads found and raises
// result_valid. Throughput: one byte per cycle while text_stall is low; the
// live-position set is updated by one pass of comparators and star-closure
// prefix logic between the input register and the state register.
// Reset clears the pattern to empty and the stream state to its start.
// When the receiver stalls, the result is held; further bytes keep flowing
// until a second last byte reaches the input register, which then stalls the
// text channel until the pending result is taken.
module casefold_wildcard_substring_match (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               text_valid,
    output logic                               text_stall,
    input  logic [7:0]                         text_byte,
    input  logic                               byte_valid,
    input  logic                               last_byte,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               found,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cwsm_pkg::*;

    // Configuration registers.
    pattern_cfg_t  pattern_reg;

    // Input register stage.
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_bv_reg;
    logic          in_last_reg;

    // Stream state and result register.
    stream_state_t state_reg;
    logic          out_valid_reg;
    logic          out_found_reg;

    stream_state_t state_next;
    logic          step_found;
    logic          out_free;
    logic          process;
    logic          text_end;
    logic          text_accept;

    assign cfg_ready = 1'b1;

    // A byte without last_byte only updates the state and can always proceed;
    // a last byte also needs the result register to be free or emptying.
    assign out_free    = !out_valid_reg || !result_stall;
    assign process     = in_valid_reg && (!in_last_reg || out_free);
    assign text_end    = process && in_last_reg;
    assign text_stall  = in_valid_reg && !process;
    assign text_accept = text_valid && !text_stall;

    assign result_valid = out_valid_reg;
    assign found        = out_found_reg;

    cwsm_step u_step (
        .state_cur  (state_reg),
        .pattern    (pattern_reg),
        .text_byte  (in_byte_reg),
        .byte_valid (in_bv_reg),
        .last_byte  (in_last_reg),
        .state_next (state_next),
        .found      (step_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pattern_reg.len <= cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    pattern_reg.bytes[CFG_DATA_W-1:0] <= cfg_data;
                REG_PATTERN_HIGH:   pattern_reg.bytes[PAT_W-1:CFG_DATA_W] <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STREAM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= text_stall ? 1'b1 : text_valid;
            if (process)
            begin
                state_reg <= state_next;
            end
            if (text_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            in_byte_reg <= text_byte;
            in_bv_reg   <= byte_valid;
            in_last_reg <= last_byte;
        end
        if (text_end)
        begin
            out_found_reg <= step_found;
        end
    end

`include "casefold_wildcard_substring_match_assert.svh"

    // The text channel only stalls while a byte waits in the input register.
    `CWSM_ASSERT_IMPLIES(a_stall_needs_pending, text_stall, in_valid_reg)

    // A last byte never overwrites a result that the receiver has not taken.
    `CWSM_ASSERT_IMPLIES(a_last_waits, in_valid_reg && in_last_reg && !out_free, text_stall)

    // After a text ends, the stream state is back at its start.
    `CWSM_ASSERT_NEXT(a_stream_cleared, text_end, state_reg == STREAM_RESET)

    // An empty pattern matches every text.
    `CWSM_ASSERT_NEXT(a_empty_matches, text_end && pattern_reg.len == '0, result_valid && found)

endmodule

// ===== test/casefold_wildcard_substring_match_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for casefold_wildcard_substring_match: directed and random texts
// are searched for configured wildcard patterns, and every found result is checked against
// a position-set predictor kept in the bench. Depends on cwsm_pkg and the matcher RTL.

module casefold_wildcard_substring_match_tb;
    import cwsm_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    // Text items per random phase, filler items included.
    localparam int PHASE_ITEMS = 600;
    // Index 3 names no register; writes to it must leave the pattern alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One text transaction as it is queued for the driver.
    typedef struct packed {
        logic [7:0] data;
        logic       real_byte;
        logic       ends_text;
    } text_xact_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  text_valid = 1'b0;
    logic                  text_stall;
    logic [7:0]            text_byte = 8'h00;
    logic                  byte_valid = 1'b0;
    logic                  last_byte = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  found;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    casefold_wildcard_substring_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .byte_valid   (byte_valid),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Transactions waiting for the driver, and found values still owed by the block.
    text_xact_t text_q[$];
    logic       expected_found[$];

    // The driver and the monitor agree on progress through these two counters.
    int text_driven_cnt = 0;
    int text_accepted_cnt = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int items_queued = 0;
    int texts_checked = 0;
    int bytes_checked = 0;
    int patterns_used = 0;

    text_xact_t next_xact;
    logic       want_found;
    logic [7:0] text_buf[$];

    // Bench copy of the pattern registers, updated when a write is accepted.
    logic [4:0]  cfg_len = '0;
    logic [63:0] cfg_low = '0;
    logic [63:0] cfg_high = '0;

    // Bench copy of the stream state. Bit p of live_pos means that pattern bytes 0..p-1
    // have matched so far; pend_pos[k] holds positions that come alive k bytes after
    // the next byte, once a multi-byte character that a wildcard started is complete.
    logic [POS_W-1:0] live_pos = POS_W'(1);
    logic [POS_W-1:0] pend_pos[3] = '{default: '0};
    logic [1:0]       cont_left = 2'd0;
    logic             matched = 1'b0;

    // Lengths above the pattern store act as a full pattern.
    function automatic int used_len();
        return (cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int p);
        return (p < 8) ? cfg_low[p*8 +: 8] : cfg_high[(p-8)*8 +: 8];
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + 8'h20 : b;
    endfunction

    // Length of the UTF-8 character that starts with this byte; anything that is not a
    // valid lead byte counts as a character of its own.
    function automatic int utf8_len(input logic [7:0] b);
        if (b >= 8'hC0 && b <= 8'hDF) return 2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3;
        if (b >= 8'hF0 && b <= 8'hF7) return 4;
        return 1;
    endfunction

    // A live star may also match nothing, so the position after it is live too.
    // Walking upward lets a run of stars close in a single pass.
    function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] set);
        logic [POS_W-1:0] s;
        s = set;
        for (int p = 0; p < used_len(); p++)
            if (s[p] && pattern_byte(p) == CH_STAR) s[p+1] = 1'b1;
        return s;
    endfunction

    task automatic clear_stream();
        live_pos = POS_W'(1);
        pend_pos[0] = '0;
        pend_pos[1] = '0;
        pend_pos[2] = '0;
        cont_left = 2'd0;
        matched = 1'b0;
    endtask

    // Advances the bench state by one accepted text transaction and, when the
    // transaction ends the text, queues the found value the block owes.
    task automatic match_text_xact(input text_xact_t x);
        logic [POS_W-1:0] set;
        logic [POS_W-1:0] next_pos;
        logic [POS_W-1:0] jump;
        logic [7:0]       c;
        int               n;
        int               clen;
        n = used_len();
        if (x.real_byte)
        begin
            clen = utf8_len(x.data);
            set = live_pos;
            // A new match may start only on a character boundary.
            if (cont_left == 2'd0)
            begin
                set[0] = 1'b1;
                cont_left = 2'(clen - 1);
            end
            else
            begin
                cont_left = cont_left - 2'd1;
            end
            set = close_stars(set);
            if (set[n]) matched = 1'b1;
            next_pos = '0;
            jump = '0;
            for (int p = 0; p < n; p++)
            begin
                if (set[p])
                begin
                    c = pattern_byte(p);
                    if (c == CH_STAR) jump[p] = 1'b1;
                    else if (c == CH_QUEST) jump[p+1] = 1'b1;
                    else if (lower_case(c) == lower_case(x.data)) next_pos[p+1] = 1'b1;
                end
            end
            // Wildcard steps finish at the end of the character that this byte leads.
            next_pos = next_pos | pend_pos[0];
            if (clen == 1) next_pos = next_pos | jump;
            pend_pos[0] = pend_pos[1] | ((clen == 2) ? jump : '0);
            pend_pos[1] = pend_pos[2] | ((clen == 3) ? jump : '0);
            pend_pos[2] = (clen == 4) ? jump : '0;
            live_pos = close_stars(next_pos);
            if (live_pos[n]) matched = 1'b1;
            bytes_checked++;
        end
        if (x.ends_text)
        begin
            // A character cut short by the end of the text still completes its step.
            set = close_stars(live_pos | pend_pos[0] | pend_pos[1] | pend_pos[2]);
            if (set[n]) matched = 1'b1;
            expected_found.push_back(matched);
            clear_stream();
            texts_checked++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Driver. Inputs change on the falling edge. A transaction that has not been taken
    // yet is held unchanged; otherwise the next queued one goes out unless the sender
    // idles this cycle. The idle choice never looks at text_stall.
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if (!(text_valid && text_accepted_cnt != text_driven_cnt))
        begin
            if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_xact = text_q.pop_front();
                text_valid <= 1'b1;
                text_byte <= next_xact.data;
                byte_valid <= next_xact.real_byte;
                last_byte <= next_xact.ends_text;
                text_driven_cnt++;
            end
            else
            begin
                text_valid <= 1'b0;
            end
        end
    end

    // Monitor. Both channels are sampled on the rising edge. The result is checked
    // before the text transaction of the same edge is predicted, since a result can
    // only belong to a text that ended earlier.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_found.size() == 0)
                begin
                    report_mismatch($sformatf("result found=%b with no text pending", found));
                end
                else
                begin
                    want_found = expected_found.pop_front();
                    if (found !== want_found)
                        report_mismatch($sformatf("found=%b, predicted %b (text %0d)",
                                                  found, want_found,
                                                  texts_checked - expected_found.size()));
                end
            end
            if (text_valid && !text_stall)
            begin
                match_text_xact('{data: text_byte, real_byte: byte_valid,
                                  ends_text: last_byte});
                text_accepted_cnt++;
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("casefold_wildcard_substring_match_tb: errors");
            $finish;
        end
    end

    // Register write; the bench copy follows at the accepting edge. cfg_valid is left
    // high so that back-to-back writes need no second assignment in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_PATTERN_LENGTH: cfg_len = data[4:0];
            REG_PATTERN_LOW:    cfg_low = data;
            REG_PATTERN_HIGH:   cfg_high = data;
            default:            ;
        endcase
    endtask

    task automatic program_pattern(input logic [63:0] len_word, input logic [127:0] bytes);
        write_reg(REG_PATTERN_LOW, bytes[63:0]);
        write_reg(REG_PATTERN_HIGH, bytes[127:64]);
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
        write_reg(REG_PATTERN_LENGTH, len_word);
        @(negedge clk);
        cfg_valid <= 1'b0;
        patterns_used++;
    endtask

    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < MAX_PATTERN; i++) w[i*8 +: 8] = s[i];
        return w;
    endfunction

    // The block is idle once everything queued has been taken and every result has
    // come back; a further wait covers the evaluation stage behind the input register.
    task automatic wait_idle();
        while (text_q.size() != 0 || text_driven_cnt != text_accepted_cnt ||
               expected_found.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_item(input logic [7:0] b, input logic real_b, input logic ends);
        text_q.push_back('{data: b, real_byte: real_b, ends_text: ends});
        items_queued++;
    endtask

    // Appends one random character: letters in either case, well-formed multi-byte
    // characters, wildcard bytes used as text, printable ASCII and fully random bytes.
    task automatic add_char();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3:
            begin
                b = 8'h61 + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1) b = b ^ CASE_BIT;
                text_buf.push_back(b);
            end
            4:
            begin
                text_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            5:
            begin
                text_buf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            6:
            begin
                text_buf.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            7: text_buf.push_back(8'($urandom_range(0, 255)));
            8: text_buf.push_back(($urandom_range(0, 1) == 1) ? CH_STAR : CH_QUEST);
            default: text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        endcase
    endtask

    function automatic logic [7:0] random_pattern_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1: b = CH_STAR;
            2, 3: b = CH_QUEST;
            9:    b = 8'hC3;
            10:   b = 8'($urandom_range(0, 255));
            11:   b = 8'($urandom_range(8'h80, 8'hBF));
            default:
            begin
                b = 8'h61 + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1) b = b ^ CASE_BIT;
            end
        endcase
        return b;
    endfunction

    // Picks a new pattern. Most are short; empty, full and oversized lengths appear
    // now and then. Bytes past the length are random, since the block must ignore them,
    // and the unused upper bits of the length word are random as well.
    task automatic new_random_pattern();
        logic [127:0] bytes;
        logic [63:0]  len_word;
        int           len;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = MAX_PATTERN;
            2:       len = $urandom_range(MAX_PATTERN + 1, 31);
            default: len = $urandom_range(1, 6);
        endcase
        for (int i = 0; i < MAX_PATTERN; i++)
            bytes[i*8 +: 8] = (i < len) ? random_pattern_byte() : 8'($urandom_range(0, 255));
        len_word = {$urandom, $urandom};
        len_word[4:0] = 5'(len);
        program_pattern(len_word, bytes);
    endtask

    // Builds one text in text_buf. Most texts carry an instance of the current pattern
    // (wildcards filled in, letters in random case) between random characters, and some
    // of those are spoiled by a changed byte or a cut-off end. The rest are pure noise
    // or empty.
    task automatic build_text();
        int         shape;
        logic [7:0] c;
        text_buf.delete();
        shape = $urandom_range(0, 9);
        if (shape >= 1 && shape <= 2)
        begin
            repeat ($urandom_range(1, 12)) add_char();
        end
        else if (shape >= 3)
        begin
            repeat ($urandom_range(0, 3)) add_char();
            for (int k = 0; k < used_len(); k++)
            begin
                c = pattern_byte(k);
                if (c == CH_STAR)
                begin
                    repeat ($urandom_range(0, 2)) add_char();
                end
                else if (c == CH_QUEST)
                begin
                    add_char();
                end
                else
                begin
                    if (lower_case(c) >= 8'h61 && lower_case(c) <= 8'h7A &&
                        $urandom_range(0, 1) == 1)
                        c = c ^ CASE_BIT;
                    text_buf.push_back(c);
                end
            end
            repeat ($urandom_range(0, 3)) add_char();
            if (text_buf.size() != 0 && $urandom_range(0, 3) == 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            if (text_buf.size() != 0 && $urandom_range(0, 4) == 0)
                void'(text_buf.pop_back());
        end
    endtask

    // Queues text_buf as transactions. Filler transactions with byte_valid low are
    // sprinkled in, and sometimes the text is closed by such a transaction instead of
    // by its last real byte. An empty text is a lone closing transaction.
    task automatic queue_text();
        logic close_apart;
        close_apart = (text_buf.size() == 0) || ($urandom_range(0, 7) == 0);
        foreach (text_buf[i])
        begin
            if ($urandom_range(0, 11) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_item(text_buf[i], 1'b1, !close_apart && i == text_buf.size() - 1);
        end
        if (close_apart) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // A random phase is a series of patterns, each followed by a handful of texts.
    // The sender waits for every result before each new pattern is written.
    task automatic run_random_phase();
        int start;
        start = items_queued;
        while (items_queued - start < PHASE_ITEMS)
        begin
            new_random_pattern();
            repeat ($urandom_range(4, 14))
            begin
                build_text();
                queue_text();
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the first idling mix.
        send_idle_pct = 20;
        recv_stall_pct = 82;

        // Out of reset the pattern is empty, so the empty text and any other text match.
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'hFF, 1'b1, 1'b1);
        wait_idle();

        // A question mark spans a three-byte character, letters fold case, and a filler
        // transaction inside the text changes nothing.
        program_pattern(64'd3, pack_text("a?c"));
        queue_item("x", 1'b1, 1'b0);
        queue_item("A", 1'b1, 1'b0);
        queue_item(8'hE2, 1'b1, 1'b0);
        queue_item(8'h82, 1'b1, 1'b0);
        queue_item(8'hAC, 1'b1, 1'b0);
        queue_item(8'h55, 1'b0, 1'b0);
        queue_item("C", 1'b1, 1'b1);
        // Extreme byte values with no match.
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1);
        wait_idle();

        // The text ends inside a four-byte character that a question mark started.
        program_pattern(64'd2, pack_text("x?"));
        queue_item("X", 1'b1, 1'b0);
        queue_item(8'hF0, 1'b1, 1'b1);
        wait_idle();

        // A star absorbs a two-byte character and a letter.
        program_pattern(64'd3, pack_text("a*b"));
        queue_item("A", 1'b1, 1'b0);
        queue_item(8'hC3, 1'b1, 1'b0);
        queue_item(8'hA9, 1'b1, 1'b0);
        queue_item("z", 1'b1, 1'b0);
        queue_item("B", 1'b1, 1'b1);
        wait_idle();

        // An all-ones length word acts as a full pattern, here sixteen stars.
        program_pattern(64'hFFFF_FFFF_FFFF_FFFF, pack_text("****************"));
        queue_item("q", 1'b1, 1'b1);
        wait_idle();

        // A full pattern of question marks cannot match an empty text.
        program_pattern(64'd16, pack_text("????????????????"));
        queue_item(8'hA5, 1'b0, 1'b1);
        wait_idle();

        // Random phases: sender gaps with heavy back-pressure, then the reverse, then
        // full rate on both sides.
        run_random_phase();
        send_idle_pct = 82;
        recv_stall_pct = 20;
        run_random_phase();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random_phase();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Searched %0d texts holding %0d bytes under %0d pattern settings,",
                 texts_checked, bytes_checked, patterns_used);
        $display("with sender gaps and result stalls in both mixes and at full rate.");
        if (mismatches == 0)
        begin
            $display("casefold_wildcard_substring_match_tb: clean");
        end
        else
        begin
            $display("casefold_wildcard_substring_match_tb: errors");
        end
        $finish;
    end

endmodule
